>>> rtl/core/cpfr_pkg.sv
// Shared types and constants for the checksummed parameter frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package cpfr_pkg;

   // Frame geometry; the frame layout is fixed at 44 bytes
   localparam int FRAME_BYTES = 44;
   localparam int SUM_W       = 14;            // 42 bytes * 255 < 2**14
   localparam logic [7:0] HEAD_LO = 8'hFF;
   localparam logic [7:0] LEN_LO  = 8'(FRAME_BYTES);

   // Byte offsets inside the frame
   localparam int OFF_ANGLE = 4;
   localparam int OFF_BKP   = 8;
   localparam int OFF_BKD   = 12;
   localparam int OFF_VKP   = 16;
   localparam int OFF_VKI   = 20;
   localparam int OFF_ENC   = 24;
   localparam int OFF_ALEN  = FRAME_BYTES - 4;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // One classified transaction passed from front to back
   typedef struct packed {
      logic        frame_ok;
      logic [31:0] angle;
      logic [31:0] b_kp;
      logic [31:0] b_kd;
      logic [31:0] v_kp;
      logic [31:0] v_ki;
      logic [31:0] enc;
   } cpfr_cmd_type;

endpackage

>>> rtl/core/cpfr_front.sv
// Front part: byte window, running checksum and frame classification.
// Depends on cpfr_pkg.
`timescale 1ns / 1ps

module cpfr_front import cpfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   input  logic         queue_ready,
   output logic         cmd_push,
   output cpfr_cmd_type cmd
);

   logic [7:0]       win_ff [FRAME_BYTES];
   logic [7:0]       win_in [FRAME_BYTES];
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_shift;
   logic             frame_ok;

   // Field of the shifted window at offset off is old window byte off+1
   function automatic logic [31:0] le32(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      le32 = {b3, b2, b1, b0};
   endfunction

   assign req_ready = queue_ready;
   assign cmd_push  = req_valid && queue_ready;

   // sum_ff holds the sum of bytes 0..41 of the current window
   assign sum_shift = sum_ff + SUM_W'(win_ff[FRAME_BYTES-2]) - SUM_W'(win_ff[0]);

   assign frame_ok = (win_ff[1] == HEAD_LO) && (win_ff[2] == 8'h00)
                  && (win_ff[3] == LEN_LO) && (win_ff[4] == 8'h00)
                  && ((win_ff[OFF_ALEN+1] & LEN_LO) == 8'h00)
                  && ({2'b00, sum_shift} == {req_rx_byte, win_ff[FRAME_BYTES-1]});

   always_comb begin
      cmd.frame_ok = frame_ok;
      cmd.angle = le32(win_ff[OFF_ANGLE+1], win_ff[OFF_ANGLE+2],
                       win_ff[OFF_ANGLE+3], win_ff[OFF_ANGLE+4]);
      cmd.b_kp  = le32(win_ff[OFF_BKP+1], win_ff[OFF_BKP+2],
                       win_ff[OFF_BKP+3], win_ff[OFF_BKP+4]);
      cmd.b_kd  = le32(win_ff[OFF_BKD+1], win_ff[OFF_BKD+2],
                       win_ff[OFF_BKD+3], win_ff[OFF_BKD+4]);
      cmd.v_kp  = le32(win_ff[OFF_VKP+1], win_ff[OFF_VKP+2],
                       win_ff[OFF_VKP+3], win_ff[OFF_VKP+4]);
      cmd.v_ki  = le32(win_ff[OFF_VKI+1], win_ff[OFF_VKI+2],
                       win_ff[OFF_VKI+3], win_ff[OFF_VKI+4]);
      cmd.enc   = le32(win_ff[OFF_ENC+1], win_ff[OFF_ENC+2],
                       win_ff[OFF_ENC+3], win_ff[OFF_ENC+4]);
   end

   always_comb begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[FRAME_BYTES-1] = req_rx_byte;
      sum_in = sum_shift;
      if (frame_ok) begin
         // accepted frame: window starts over from all zero
         for (int i = 0; i < FRAME_BYTES; i++) begin
            win_in[i] = 8'h00;
         end
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            win_ff[i] <= 8'h00;
         end
         sum_ff <= '0;
      end else if (cmd_push) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            win_ff[i] <= win_in[i];
         end
         sum_ff <= sum_in;
      end
   end

`ifndef SYNTHESIS
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd_push && frame_ok |=> sum_ff == '0)
      else $error("running sum not cleared after accepted frame");
`endif

endmodule

>>> rtl/core/cpfr_queue.sv
// Short queue of classified transactions between front and back parts.
// Depends on cpfr_pkg.
`timescale 1ns / 1ps

module cpfr_queue import cpfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cpfr_cmd_type push_cmd,
   output logic         not_full,
   input  logic         pop,
   output logic         not_empty,
   output cpfr_cmd_type head_cmd
);

   cpfr_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign not_full  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
`endif

endmodule

>>> rtl/core/cpfr_back.sv
// Back part: held parameter registers and the result output register.
// Depends on cpfr_pkg.
`timescale 1ns / 1ps

module cpfr_back import cpfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cpfr_cmd_type       cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_accepted,
   output logic signed [31:0] rsp_balance_angle,
   output logic signed [31:0] rsp_balance_kp,
   output logic signed [31:0] rsp_balance_kd,
   output logic signed [31:0] rsp_velocity_kp,
   output logic signed [31:0] rsp_velocity_ki,
   output logic signed [31:0] rsp_encoder_filter
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff;
   logic [31:0] angle_ff, angle_in;
   logic [31:0] b_kp_ff, b_kp_in;
   logic [31:0] b_kd_ff, b_kd_in;
   logic [31:0] v_kp_ff, v_kp_in;
   logic [31:0] v_ki_ff, v_ki_in;
   logic [31:0] enc_ff, enc_in;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end
      // on an accepted frame the angle always loads; the other fields only when nonzero
      angle_in = cmd.frame_ok ? cmd.angle : angle_ff;
      b_kp_in  = (cmd.frame_ok && cmd.b_kp != '0) ? cmd.b_kp : b_kp_ff;
      b_kd_in  = (cmd.frame_ok && cmd.b_kd != '0) ? cmd.b_kd : b_kd_ff;
      v_kp_in  = (cmd.frame_ok && cmd.v_kp != '0) ? cmd.v_kp : v_kp_ff;
      v_ki_in  = (cmd.frame_ok && cmd.v_ki != '0) ? cmd.v_ki : v_ki_ff;
      enc_in   = (cmd.frame_ok && cmd.enc  != '0) ? cmd.enc  : enc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
         angle_ff     <= '0;
         b_kp_ff      <= '0;
         b_kd_ff      <= '0;
         v_kp_ff      <= '0;
         v_ki_ff      <= '0;
         enc_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            accepted_ff <= cmd.frame_ok;
            angle_ff    <= angle_in;
            b_kp_ff     <= b_kp_in;
            b_kd_ff     <= b_kd_in;
            v_kp_ff     <= v_kp_in;
            v_ki_ff     <= v_ki_in;
            enc_ff      <= enc_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_accepted = accepted_ff;
   assign rsp_balance_angle  = signed'(angle_ff);
   assign rsp_balance_kp     = signed'(b_kp_ff);
   assign rsp_balance_kd     = signed'(b_kd_ff);
   assign rsp_velocity_kp    = signed'(v_kp_ff);
   assign rsp_velocity_ki    = signed'(v_ki_ff);
   assign rsp_encoder_filter = signed'(enc_ff);

`ifndef SYNTHESIS
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_valid_ff)
      else $error("popped transaction not presented");
   a_hold_no_frame: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && !cmd.frame_ok |=> $stable(angle_ff) && $stable(b_kp_ff) && $stable(enc_ff))
      else $error("held value changed without accepted frame");
`endif

endmodule

>>> rtl/core/checksummed_parameter_frame_receiver_top.sv
// Top level of the checksummed parameter frame receiver.
// Depends on cpfr_pkg, cpfr_front, cpfr_queue and cpfr_back.
// rsp_valid follows an accepted byte transaction through the queue entry, then the output register.
// Throughput: one byte per cycle while the queue has room, set by the window shift and checksum update.
// Reset (synchronous, active high) clears the window, running sum, queue and held values.
`timescale 1ns / 1ps

module checksummed_parameter_frame_receiver_top import cpfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_accepted,
   output logic signed [31:0] rsp_balance_angle,
   output logic signed [31:0] rsp_balance_kp,
   output logic signed [31:0] rsp_balance_kd,
   output logic signed [31:0] rsp_velocity_kp,
   output logic signed [31:0] rsp_velocity_ki,
   output logic signed [31:0] rsp_encoder_filter
);

   // Front -> queue
   logic         q_not_full;
   logic         cmd_push;
   cpfr_cmd_type front_cmd;

   // Queue -> back
   logic         q_not_empty;
   logic         cmd_pop;
   cpfr_cmd_type head_cmd;

   // Front: slides the 44-byte window and keeps a running sum of bytes 0..41,
   // so every byte transaction is classified in the cycle it arrives.
   cpfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_ready (q_not_full),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd)
   );

   // Two-entry queue lets the front keep taking bytes while a result stalls.
   cpfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (front_cmd),
      .not_full  (q_not_full),
      .pop       (cmd_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // Back: applies accepted frames to the held values (all but the angle only
   // when nonzero) and registers one result per transaction.
   cpfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (q_not_empty),
      .cmd                (head_cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_balance_angle  (rsp_balance_angle),
      .rsp_balance_kp     (rsp_balance_kp),
      .rsp_balance_kd     (rsp_balance_kd),
      .rsp_velocity_kp    (rsp_velocity_kp),
      .rsp_velocity_ki    (rsp_velocity_ki),
      .rsp_encoder_filter (rsp_encoder_filter)
   );

endmodule

>>> tb/checksummed_parameter_frame_receiver_top_tb.sv
// Testbench for checksummed_parameter_frame_receiver_top: byte stream in, one report per byte out.
// Depends on cpfr_pkg and the receiver RTL; holds its own frame predictor and scoreboard.
`timescale 1ns / 1ps

module checksummed_parameter_frame_receiver_top_tb;
   import cpfr_pkg::*;

   // Frame constants the predictor needs beyond what the package offers
   localparam logic [15:0] FRAME_HEAD = 16'h00FF;
   localparam int          SUM_OFF    = FRAME_BYTES - 2;
   localparam int          TURN_OFF   = 28;

   localparam int WATCHDOG_CYCLES = 2000;  // idle cycles before the run is declared hung
   localparam int HOLD_CYCLES     = 120;   // long receiver hold-off, well past the queue depth
   localparam int ITEM_TARGET     = 440;   // total byte transactions, directed part included
   localparam int DRAIN_CYCLES    = 10;    // settle time after the last report

   // How a generated frame is broken, if at all
   typedef enum int {
      FAULT_NONE,
      FAULT_HEAD_LO,
      FAULT_HEAD_HI,
      FAULT_LEN_LO,
      FAULT_LEN_HI,
      FAULT_ALEN,
      FAULT_SUM
   } frame_fault_type;

   // Receiver back-pressure styles, picked at random on a regular period
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_MOSTLY,
      RX_PATTERN
   } stall_mode_type;

   // One report as it appears on the rsp_ channel
   typedef struct packed {
      logic        accepted;
      logic [31:0] angle;
      logic [31:0] bal_kp;
      logic [31:0] bal_kd;
      logic [31:0] vel_kp;
      logic [31:0] vel_ki;
      logic [31:0] enc_filter;
   } param_report_type;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the 44-byte sliding window and the held
   // parameters, queues the report each accepted byte must produce, and
   // checks reports in order as they leave the block.
   // ------------------------------------------------------------------
   class frame_scoreboard;
      logic [7:0]       window [FRAME_BYTES];
      param_report_type held;
      param_report_type report_q [$];
      int               mismatches;
      int               reports_checked;
      int               frames_taken;

      function new();
         foreach (window[i]) window[i] = 8'h00;
         held            = '0;
         mismatches      = 0;
         reports_checked = 0;
         frames_taken    = 0;
      endfunction

      // Little-endian word at a frame offset
      function logic [31:0] le_word(int off);
         return {window[off + 3], window[off + 2], window[off + 1], window[off]};
      endfunction

      function bit frame_ok();
         logic [15:0] len;
         int          total;
         len   = {window[3], window[2]};
         total = 0;
         if ({window[1], window[0]} != FRAME_HEAD) return 1'b0;
         if (len != 16'(FRAME_BYTES)) return 1'b0;
         if ((len & {window[OFF_ALEN + 1], window[OFF_ALEN]}) != 16'h0000) return 1'b0;
         for (int i = 0; i < SUM_OFF; i++) total += window[i];
         // 42 bytes sum to at most 10710, so 16 bits hold it exactly
         return 16'(total) == {window[SUM_OFF + 1], window[SUM_OFF]};
      endfunction

      // Byte accepted by the block: shift it in and predict the report
      function void note_byte(logic [7:0] b);
         logic [31:0] v;
         for (int k = 0; k < FRAME_BYTES - 1; k++) window[k] = window[k + 1];
         window[FRAME_BYTES - 1] = b;
         held.accepted = frame_ok();
         if (held.accepted) begin
            held.angle = le_word(OFF_ANGLE);
            // zero gains leave the held value alone
            v = le_word(OFF_BKP);
            if (v != 0) held.bal_kp = v;
            v = le_word(OFF_BKD);
            if (v != 0) held.bal_kd = v;
            v = le_word(OFF_VKP);
            if (v != 0) held.vel_kp = v;
            v = le_word(OFF_VKI);
            if (v != 0) held.vel_ki = v;
            v = le_word(OFF_ENC);
            if (v != 0) held.enc_filter = v;
            foreach (window[i]) window[i] = 8'h00;
            frames_taken++;
         end
         report_q.push_back(held);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
         end
      endfunction

      function void check_report(param_report_type got);
         param_report_type want;
         reports_checked++;
         if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] report with nothing outstanding: %h", $time, got);
            return;
         end
         want = report_q.pop_front();
         compare_field("frame_accepted", 32'(want.accepted), 32'(got.accepted));
         compare_field("balance_angle", want.angle, got.angle);
         compare_field("balance_kp", want.bal_kp, got.bal_kp);
         compare_field("balance_kd", want.bal_kd, got.bal_kd);
         compare_field("velocity_kp", want.vel_kp, got.vel_kp);
         compare_field("velocity_ki", want.vel_ki, got.vel_ki);
         compare_field("encoder_filter", want.enc_filter, got.enc_filter);
      endfunction

      function int outstanding();
         return report_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic               rsp_frame_accepted;
   logic signed [31:0] rsp_balance_angle;
   logic signed [31:0] rsp_balance_kp;
   logic signed [31:0] rsp_balance_kd;
   logic signed [31:0] rsp_velocity_kp;
   logic signed [31:0] rsp_velocity_ki;
   logic signed [31:0] rsp_encoder_filter;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   checksummed_parameter_frame_receiver_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_balance_angle  (rsp_balance_angle),
      .rsp_balance_kp     (rsp_balance_kp),
      .rsp_balance_kd     (rsp_balance_kd),
      .rsp_velocity_kp    (rsp_velocity_kp),
      .rsp_velocity_ki    (rsp_velocity_ki),
      .rsp_encoder_filter (rsp_encoder_filter)
   );

   frame_scoreboard sb;

   // Stimulus state; hold_seq is also read by the receiver process
   int         hold_seq   = 0;   // bumped by the stimulus to request one long hold-off
   int         burst_left = 0;   // bytes left in the sender's current burst
   int         bytes_sent = 0;
   logic [7:0] frame_buf [FRAME_BYTES];

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, before any of
   // this edge's nonblocking updates land, so a transaction is exactly
   // valid && ready as seen here.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready)
            sb.check_report(param_report_type'({rsp_frame_accepted, rsp_balance_angle,
                                                 rsp_balance_kp, rsp_balance_kd,
                                                 rsp_velocity_kp, rsp_velocity_ki,
                                                 rsp_encoder_filter}));
      end
   end

   // ------------------------------------------------------------------
   // Receiver: back-pressure style is picked at random on a regular period; includes a
   // stretch of always-ready. A request from the stimulus starts a long
   // hold-off counted here, so the block's queue fills and req_ready drops.
   // ------------------------------------------------------------------
   int             rx_cycle;
   int             hold_seen;
   int             hold_left;
   stall_mode_type rx_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  <= 0;
         hold_seen <= 0;
         hold_left <= 0;
         rx_mode   <= RX_ALWAYS;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 50 == 0)
            rx_mode <= stall_mode_type'($urandom_range(RX_ALWAYS, RX_PATTERN));
         if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
               default:   rsp_ready <= ((rx_cycle % 7) >= 3);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: ends the run if no transaction happens on either channel
   // for too long. The longest legal quiet stretch is the hold-off.
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   initial begin
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender: bursts of 1..40 bytes separated by idle gaps. Valid
   // stays up across back-to-back bytes; it only drops at a burst end.
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // First count bytes of the frame buffer; fewer than 44 gives a cut-off frame
   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) send_byte(frame_buf[i]);
   endtask

   // Stop offering bytes until every queued report has come out
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Gain values biased toward zero and the 32-bit extremes
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // alen that never shares a bit with len
   function automatic logic [15:0] rand_alen();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return ~16'(FRAME_BYTES);
         default: return 16'($urandom) & ~16'(FRAME_BYTES);
      endcase
   endfunction

   // Fill frame_buf with one frame: header, six words, turn bytes,
   // alen and a correct sum, then apply the requested fault.
   function automatic void make_frame(input logic [31:0] angle, input logic [31:0] bkp,
                                      input logic [31:0] bkd, input logic [31:0] vkp,
                                      input logic [31:0] vki, input logic [31:0] enc,
                                      input logic [15:0] alen, input frame_fault_type fault,
                                      input bit turn_max);
      logic [31:0] words [6];
      logic [15:0] alen_v;
      int          total;
      words  = '{angle, bkp, bkd, vkp, vki, enc};
      alen_v = alen;
      total  = 0;
      frame_buf[0] = FRAME_HEAD[7:0];
      frame_buf[1] = FRAME_HEAD[15:8];
      frame_buf[2] = 8'(FRAME_BYTES);
      frame_buf[3] = 8'h00;
      for (int w = 0; w < 6; w++)
         for (int k = 0; k < 4; k++)
            frame_buf[OFF_ANGLE + 4 * w + k] = words[w][8 * k +: 8];
      for (int i = TURN_OFF; i < OFF_ALEN; i++)
         frame_buf[i] = turn_max ? 8'hFF : 8'($urandom);
      case (fault)
         FAULT_HEAD_LO: frame_buf[0] = 8'($urandom_range(0, 254));
         FAULT_HEAD_HI: frame_buf[1] = 8'($urandom_range(1, 255));
         FAULT_LEN_LO:  frame_buf[2] = 8'(FRAME_BYTES + $urandom_range(1, 255));
         FAULT_LEN_HI:  frame_buf[3] = 8'($urandom_range(1, 255));
         FAULT_ALEN: begin
            // force one bit in common with len (44 = bits 2, 3, 5)
            case ($urandom_range(0, 2))
               0:       alen_v = alen_v | 16'h0004;
               1:       alen_v = alen_v | 16'h0008;
               default: alen_v = alen_v | 16'h0020;
            endcase
         end
         default: ;
      endcase
      frame_buf[OFF_ALEN]     = alen_v[7:0];
      frame_buf[OFF_ALEN + 1] = alen_v[15:8];
      for (int i = 0; i < SUM_OFF; i++) total += frame_buf[i];
      if (fault == FAULT_SUM) total = total ^ $urandom_range(1, 65535);
      frame_buf[SUM_OFF]     = total[7:0];
      frame_buf[SUM_OFF + 1] = total[15:8];
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int directed_bytes;
      int pick;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stray bytes at the extremes on an all-zero window
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);

      // Most fields at an extreme, turn bytes all ones for a near-maximal sum
      make_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h7FFF_FFFF, 32'h1234_5678, 16'h0000, FAULT_NONE, 1'b1);
      send_frame(FRAME_BYTES);

      // Straight after a clear: negative angle, all gains zero so every gain holds,
      // alen with every bit outside len set
      make_frame(32'h8000_0000, 0, 0, 0, 0, 0, ~16'(FRAME_BYTES), FAULT_NONE, 1'b0);
      send_frame(FRAME_BYTES);

      // One frame per check that can reject it; the receiver holds off while
      // these go out, so the queue fills and the input stalls
      hold_seq <= hold_seq + 1;
      for (int f = FAULT_HEAD_LO; f <= FAULT_SUM; f++) begin
         make_frame(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444,
                    32'h5555_5555, 32'h6666_6666, 16'h0000, frame_fault_type'(f), 1'b0);
         send_frame(FRAME_BYTES);
      end
      drain_reports();

      // A cut-off frame, then a full one: the window has to resync on the tail.
      // The full frame has a zero angle, which is still copied, and only some
      // gains nonzero, so only those update.
      make_frame(32'hDEAD_BEEF, 32'h0000_0007, 0, 0, 0, 0, 16'h0000, FAULT_NONE, 1'b0);
      send_frame(20);
      make_frame(32'h0000_0000, 0, 32'h0000_0005, 0, 32'hFFFF_FFFF, 32'h8000_0001,
                 16'h0000, FAULT_NONE, 1'b0);
      send_frame(FRAME_BYTES);
      directed_bytes = bytes_sent;

      // Random part: mostly well-formed frames with random content, some broken
      // or cut-off frames, and noise
      while (bytes_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            make_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_alen(), FAULT_NONE, 1'b0);
            send_frame(FRAME_BYTES);
         end else if (pick < 15) begin
            make_frame(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_alen(),
                       frame_fault_type'($urandom_range(FAULT_HEAD_LO, FAULT_SUM)), 1'b0);
            send_frame(FRAME_BYTES);
         end else if (pick < 17) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
         end else if (pick < 19) begin
            make_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_alen(), FAULT_NONE, 1'b0);
            send_frame($urandom_range(1, FRAME_BYTES - 1));
         end else begin
            make_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_alen(), FAULT_NONE, 1'b1);
            send_frame(FRAME_BYTES);
         end
      end

      // Wind down: wait for every report, then wait DRAIN_CYCLES for strays
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d byte transactions (%0d directed) and %0d reports checked.",
               bytes_sent, directed_bytes, sb.reports_checked);
      $display("Frames accepted: %0d; field mismatches: %0d.",
               sb.frames_taken, sb.mismatches);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
